### hdl/pmdc_pkg.sv
package pmdc_pkg;

    localparam int ADC_W  = 12;
    localparam int DUTY_W = 7;
    localparam int TICK_W = 24;
    localparam int IDX_W  = 2;
    localparam int PROD_W = 19;
    localparam int MUL_W  = 31;
    localparam int CNT_W  = 5;

    localparam logic [ADC_W-1:0]  FULL_SCALE   = 12'hFFF;
    localparam logic [ADC_W-1:0]  MID_CW_MAX   = 12'h7FF;
    localparam logic [ADC_W-1:0]  CCW_SPAN     = 12'h800;
    localparam logic [ADC_W-1:0]  STEP_RESET   = 12'd64;
    localparam logic [TICK_W-1:0] PERIOD_RESET = 24'd80000;
    localparam logic [DUTY_W-1:0] PERCENT      = 7'd100;

    localparam logic [CNT_W-1:0] DUTY_LAST = 5'd6;
    localparam logic [CNT_W-1:0] MUL_LAST  = 5'd6;
    localparam logic [CNT_W-1:0] DIV_LAST  = 5'd23;

    typedef enum logic [IDX_W-1:0] {
        REG_MODE   = 2'd0,
        REG_STEP   = 2'd1,
        REG_PERIOD = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLEW,
        ST_PREP,
        ST_DUTY,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

### hdl/pot_motor_duty_controller.sv
// Channel   Handshake               Payload
// in        in_valid / in_stall     sample_valid, adc_value, key_valid, key_direction
// out       out_valid / out_stall   direction, duty_percent, on_ticks, off_ticks
// cfg       cfg_write               cfg_index, cfg_data
//
// An accepted input runs through SLEW, PREP and DUTY (the latter two only with a valid
// sample), MUL, DIV and DONE. The bit-serial units take 7 steps of duty division, 7 steps
// of shift-add multiply by the period, 24 steps of division by 100.
// One transaction at a time; in_stall is low only while the datapath is idle.
// The output register holds a finished result while the next input is accepted.
// rst_n clears control state and loads the register reset values asynchronously.
module pot_motor_duty_controller
    import pmdc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                sample_valid,
    input  logic [ADC_W-1:0]    adc_value,
    input  logic                key_valid,
    input  logic                key_direction,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                direction,
    output logic [DUTY_W-1:0]   duty_percent,
    output logic [TICK_W-1:0]   on_ticks,
    output logic [TICK_W-1:0]   off_ticks,
    input  logic                cfg_write,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [TICK_W-1:0]   cfg_data
);

    state_t state_reg, state_next;

    logic                mode_reg;
    logic [ADC_W-1:0]    step_reg;
    logic [TICK_W-1:0]   period_reg;

    logic [ADC_W-1:0]    smooth_reg, smooth_next;
    logic                dir_reg, dir_next;
    logic [DUTY_W-1:0]   duty_reg, duty_next;

    logic                smp_vld_reg;
    logic [ADC_W-1:0]    adc_reg;
    logic                key_vld_reg;
    logic                key_dir_reg;

    logic [ADC_W-1:0]    den_reg, den_next;
    logic [ADC_W-1:0]    rem_reg, rem_next;
    logic [MUL_W-1:0]    sh_reg, sh_next;
    logic [DUTY_W-1:0]   mul_reg, mul_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_dir_reg, out_dir_next;
    logic [DUTY_W-1:0]   out_duty_reg, out_duty_next;
    logic [TICK_W-1:0]   out_on_reg, out_on_next;
    logic [TICK_W-1:0]   out_off_reg, out_off_next;

    logic                accept;
    logic                slot_free;

    logic [ADC_W-1:0]    up_diff, dn_diff, slew_val;
    logic [ADC_W-1:0]    num, den;
    logic [PROD_W-1:0]   prod;

    logic [ADC_W:0]      d_trial, d_sub;
    logic                d_ge;
    logic [ADC_W-1:0]    d_rem;
    logic [DUTY_W-1:0]   d_quo;

    logic [MUL_W-1:0]    m_acc;

    logic [DUTY_W:0]     t_trial, t_sub;
    logic                t_ge;

    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign direction    = out_dir_reg;
    assign duty_percent = out_duty_reg;
    assign on_ticks     = out_on_reg;
    assign off_ticks    = out_off_reg;

    // slew limiter
    always_comb
    begin
        up_diff = adc_reg - smooth_reg;
        dn_diff = smooth_reg - adc_reg;
        if (adc_reg > smooth_reg && up_diff > step_reg)
            slew_val = smooth_reg + step_reg;
        else if (smooth_reg > adc_reg && dn_diff > step_reg)
            slew_val = smooth_reg - step_reg;
        else
            slew_val = adc_reg;
    end

    // duty numerator and divisor
    always_comb
    begin
        if (!mode_reg)
        begin
            num = smooth_reg;
            den = FULL_SCALE;
        end
        else if (adc_reg <= MID_CW_MAX)
        begin
            num = (smooth_reg > MID_CW_MAX) ? '0 : MID_CW_MAX - smooth_reg;
            den = MID_CW_MAX;
        end
        else
        begin
            num = (smooth_reg < MID_CW_MAX) ? '0 : smooth_reg - MID_CW_MAX;
            den = CCW_SPAN;
        end
        prod = {1'b0, num, 6'b0} + {2'b0, num, 5'b0} + {5'b0, num, 2'b0};
    end

    // one step of each serial unit
    always_comb
    begin
        d_trial = {rem_reg, sh_reg[DUTY_W-1]};
        d_sub   = d_trial - {1'b0, den_reg};
        d_ge    = (d_trial >= {1'b0, den_reg});
        d_rem   = d_ge ? d_sub[ADC_W-1:0] : d_trial[ADC_W-1:0];
        d_quo   = {sh_reg[DUTY_W-2:0], d_ge};

        m_acc = {sh_reg[MUL_W-2:0], 1'b0}
              + (mul_reg[DUTY_W-1] ? {{(MUL_W-TICK_W){1'b0}}, period_reg} : '0);

        t_trial = {rem_reg[DUTY_W-1:0], sh_reg[TICK_W-1]};
        t_sub   = t_trial - {1'b0, PERCENT};
        t_ge    = (t_trial >= {1'b0, PERCENT});
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_SLEW;
            ST_SLEW: state_next = smp_vld_reg ? ST_PREP : ST_MUL;
            ST_PREP: state_next = ST_DUTY;
            ST_DUTY: if (cnt_reg == DUTY_LAST) state_next = ST_MUL;
            ST_MUL:  if (cnt_reg == MUL_LAST) state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == DIV_LAST) state_next = ST_DONE;
            ST_DONE: if (slot_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        smooth_next    = smooth_reg;
        dir_next       = dir_reg;
        duty_next      = duty_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        sh_next        = sh_reg;
        mul_next       = mul_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_dir_next   = out_dir_reg;
        out_duty_next  = out_duty_reg;
        out_on_next    = out_on_reg;
        out_off_next   = out_off_reg;
        case (state_reg)
            ST_IDLE: ;
            ST_SLEW:
            begin
                if (smp_vld_reg)
                    smooth_next = slew_val;
                if (!mode_reg && key_vld_reg)
                    dir_next = key_dir_reg;
                else if (mode_reg && smp_vld_reg)
                    dir_next = (adc_reg > MID_CW_MAX);
                mul_next = duty_reg;
                sh_next  = '0;
                cnt_next = '0;
            end
            ST_PREP:
            begin
                den_next = den;
                rem_next = prod[PROD_W-1:DUTY_W];
                sh_next  = {{(MUL_W-DUTY_W){1'b0}}, prod[DUTY_W-1:0]};
                cnt_next = '0;
            end
            ST_DUTY:
            begin
                rem_next = d_rem;
                sh_next  = {sh_reg[MUL_W-1:DUTY_W], d_quo};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DUTY_LAST)
                begin
                    duty_next = d_quo;
                    mul_next  = d_quo;
                    sh_next   = '0;
                    cnt_next  = '0;
                end
            end
            ST_MUL:
            begin
                sh_next  = m_acc;
                mul_next = {mul_reg[DUTY_W-2:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == MUL_LAST)
                begin
                    rem_next = {{(ADC_W-DUTY_W){1'b0}}, m_acc[MUL_W-1:TICK_W]};
                    cnt_next = '0;
                end
            end
            ST_DIV:
            begin
                rem_next = {{(ADC_W-DUTY_W){1'b0}},
                            (t_ge ? t_sub[DUTY_W-1:0] : t_trial[DUTY_W-1:0])};
                sh_next  = {sh_reg[MUL_W-1:TICK_W], sh_reg[TICK_W-2:0], t_ge};
                cnt_next = (cnt_reg == DIV_LAST) ? '0 : cnt_reg + 5'd1;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_dir_next   = dir_reg;
                    out_duty_next  = duty_reg;
                    out_on_next    = sh_reg[TICK_W-1:0];
                    out_off_next   = period_reg - sh_reg[TICK_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b0;
            step_reg      <= STEP_RESET;
            period_reg    <= PERIOD_RESET;
            smooth_reg    <= FULL_SCALE;
            dir_reg       <= 1'b0;
            duty_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            smooth_reg    <= smooth_next;
            dir_reg       <= dir_next;
            duty_reg      <= duty_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MODE:   mode_reg   <= cfg_data[0];
                    REG_STEP:   step_reg   <= cfg_data[ADC_W-1:0];
                    REG_PERIOD: period_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smp_vld_reg <= sample_valid;
            adc_reg     <= adc_value;
            key_vld_reg <= key_valid;
            key_dir_reg <= key_direction;
        end
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        sh_reg       <= sh_next;
        mul_reg      <= mul_next;
        out_dir_reg  <= out_dir_next;
        out_duty_reg <= out_duty_next;
        out_on_reg   <= out_on_next;
        out_off_reg  <= out_off_next;
    end

    a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
        duty_reg <= PERCENT)
        else $error("duty above full scale");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_SLEW)
        else $error("accepted transaction did not start");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside completion");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg <= DIV_LAST)
        else $error("division step count overrun");

endmodule
